// ----- design/gde_pkg.sv -----
`default_nettype none
package gde_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_DEGREE_DEF   = 16;

   localparam int IDX_W       = 5;
   localparam int LAB_W       = 16;
   localparam int ST_W        = 2;
   localparam int REQ_W       = 2;
   localparam int STACK_DEPTH = 32;
   localparam int SP_W        = 5;
   localparam int TOP_W       = 6;
   localparam int CMP_W       = 8;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_VERTEX = 2'd1;
   localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_LIST  = 2'd1;
   localparam logic [ST_W-1:0] ST_TABLE = 2'd2;

   typedef struct packed {
      logic clear;
      logic lab_we;
      logic cnt_we;
      logic nbr_we;
   } gde_wen_type;

endpackage
`default_nettype wire

// ----- design/gde_if.sv -----
`default_nettype none
interface gde_req_if;
   import gde_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_W-1:0]        req_type;
   logic [IDX_W-1:0]        vertex_a;
   logic [IDX_W-1:0]        vertex_b;
   logic signed [LAB_W-1:0] label_in;
   modport source (output valid, req_type, vertex_a, vertex_b, label_in, input ready);
   modport sink (input valid, req_type, vertex_a, vertex_b, label_in, output ready);
endinterface

interface gde_rsp_if;
   import gde_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic [IDX_W-1:0]        visited_index;
   logic signed [LAB_W-1:0] visited_label;
   logic                    is_visit;
   logic                    last;
   modport source (output valid, status, visited_index, visited_label, is_visit, last,
                   input ready);
   modport sink (input valid, status, visited_index, visited_label, is_visit, last,
                 output ready);
endinterface
`default_nettype wire

// ----- design/gde_store.sv -----
`default_nettype none
module gde_store
   import gde_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
   localparam int VW  = $clog2(MAX_VERTICES),
   localparam int DW  = $clog2(MAX_DEGREE + 1),
   localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gde_wen_type       wen,
   input  wire logic [VW-1:0]     lab_waddr,
   input  wire logic [LAB_W-1:0]  lab_wdata,
   input  wire logic [VW-1:0]     lab_raddr,
   output      logic [LAB_W-1:0]  lab_rdata,
   input  wire logic [VW-1:0]     cnt_waddr,
   input  wire logic [DW-1:0]     cnt_wdata,
   input  wire logic [VW-1:0]     cnt_raddr,
   output      logic [DW-1:0]     cnt_rdata,
   input  wire logic [NAW-1:0]    nbr_waddr,
   input  wire logic [IDX_W-1:0]  nbr_wdata,
   input  wire logic [NAW-1:0]    nbr_raddr,
   output      logic [IDX_W-1:0]  nbr_rdata
);

   logic [LAB_W-1:0]        lab_mem [MAX_VERTICES];
   logic [DW-1:0]           cnt_mem [MAX_VERTICES];
   logic [IDX_W-1:0]        nbr_mem [MAX_VERTICES*MAX_DEGREE];
   logic [MAX_VERTICES-1:0] lab_vld_ff;
   logic [MAX_VERTICES-1:0] cnt_vld_ff;
   logic [LAB_W-1:0]        lab_q_ff;
   logic [DW-1:0]           cnt_q_ff;
   logic                    lab_vq_ff;
   logic                    cnt_vq_ff;
   logic [IDX_W-1:0]        nbr_q_ff;

   always_ff @(posedge clock) begin
      if (reset || wen.clear) begin
         lab_vld_ff <= '0;
         cnt_vld_ff <= '0;
      end else begin
         if (wen.lab_we) lab_vld_ff[lab_waddr] <= 1'b1;
         if (wen.cnt_we) cnt_vld_ff[cnt_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wen.lab_we) lab_mem[lab_waddr] <= lab_wdata;
      if (wen.cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (wen.nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
      lab_q_ff  <= lab_mem[lab_raddr];
      lab_vq_ff <= lab_vld_ff[lab_raddr];
      cnt_q_ff  <= cnt_mem[cnt_raddr];
      cnt_vq_ff <= cnt_vld_ff[cnt_raddr];
      nbr_q_ff  <= nbr_mem[nbr_raddr];
   end

   assign lab_rdata = lab_vq_ff ? lab_q_ff : '0;
   assign cnt_rdata = cnt_vq_ff ? cnt_q_ff : '0;
   assign nbr_rdata = nbr_q_ff;

endmodule
`default_nettype wire

// ----- design/graph_dfs_engine.sv -----
// graph_dfs_engine: undirected graph store with depth-first search
// req_ch carries one request transaction: clear, add vertex, add edge or run
// search. rsp_ch returns results; every request gives one acknowledgement with
// last set, except an accepted search, which returns one visit per reached vertex in
// visit order, the final one with last set.
// one request is handled at a time; req_ch.ready is high only while idle.
// clear, add vertex and an edge or search with an out-of-range vertex go straight to the result.
// add edge: two count reads and two list writes, one at a time, then the result.
// search: a sequencer walks the stack; each step reads a count,
// then scans the neighbour list one entry at a time through the single
// list read port; a new visit adds a read of its label.
// a visit is held one step so the last one can be marked.
// reset is synchronous and empties the graph; no clearing pass is needed.
// a stalled rsp_ch holds its result and the sequencer waits on it.
`default_nettype none
module graph_dfs_engine
   import gde_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
   input wire logic clock,
   input wire logic reset,
   gde_req_if.sink   req_ch,
   gde_rsp_if.source rsp_ch
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int DW  = $clog2(MAX_DEGREE + 1);
   localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int VCW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_ACK  = 12'b000000000010,
      S_EA   = 12'b000000000100,
      S_EB   = 12'b000000001000,
      S_EC   = 12'b000000010000,
      S_ED   = 12'b000000100000,
      S_SLAB = 12'b000001000000,
      S_STOP = 12'b000010000000,
      S_SCNT = 12'b000100000000,
      S_SCAN = 12'b001000000000,
      S_SNB  = 12'b010000000000,
      S_SFIN = 12'b100000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        a_ff, a_in, b_ff, b_in, cur_ff, cur_in;
   logic [ST_W-1:0]         st_ff, st_in;
   logic [DW-1:0]           ca_ff, ca_in, cb_ff, cb_in, c_ff, c_in;
   logic [TOP_W-1:0]        top_ff, top_in;
   logic [IDX_W-1:0]        stack_ff [STACK_DEPTH];
   logic [IDX_W-1:0]        stack_in [STACK_DEPTH];
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [VCW-1:0]          vcnt_ff, vcnt_in;
   logic                    hold_v_ff, hold_v_in;
   logic [IDX_W-1:0]        hold_idx_ff, hold_idx_in;
   logic [LAB_W-1:0]        hold_lab_ff, hold_lab_in;

   logic                    out_v_ff, out_v_in;
   logic [ST_W-1:0]         out_st_ff, out_st_in;
   logic [IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic [LAB_W-1:0]        out_lab_ff, out_lab_in;
   logic                    out_vis_ff, out_vis_in;
   logic                    out_last_ff, out_last_in;

   gde_wen_type             wen;
   logic [VW-1:0]           lab_waddr, lab_raddr, cnt_waddr, cnt_raddr;
   logic [LAB_W-1:0]        lab_wdata, lab_rdata;
   logic [DW-1:0]           cnt_wdata, cnt_rdata, slot;
   logic [NAW-1:0]          nbr_waddr, nbr_raddr;
   logic [IDX_W-1:0]        nbr_wdata, nbr_rdata, v_top;
   logic                    out_free, out_load, a_bad, b_bad, self, full;
   logic [CMP_W-1:0]        ca_w, cb_w;

   gde_store #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_DEGREE  (MAX_DEGREE)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wen      (wen),
      .lab_waddr(lab_waddr),
      .lab_wdata(lab_wdata),
      .lab_raddr(lab_raddr),
      .lab_rdata(lab_rdata),
      .cnt_waddr(cnt_waddr),
      .cnt_wdata(cnt_wdata),
      .cnt_raddr(cnt_raddr),
      .cnt_rdata(cnt_rdata),
      .nbr_waddr(nbr_waddr),
      .nbr_wdata(nbr_wdata),
      .nbr_raddr(nbr_raddr),
      .nbr_rdata(nbr_rdata)
   );

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign a_bad    = CMP_W'(req_ch.vertex_a) >= CMP_W'(MAX_VERTICES);
   assign b_bad    = CMP_W'(req_ch.vertex_b) >= CMP_W'(MAX_VERTICES);
   assign self     = (a_ff == b_ff);
   assign ca_w     = CMP_W'(ca_ff);
   assign cb_w     = CMP_W'(cnt_rdata);
   assign full     = self ? (ca_w + CMP_W'(2) > CMP_W'(MAX_DEGREE))
                          : (ca_w + CMP_W'(1) > CMP_W'(MAX_DEGREE)) ||
                            (cb_w + CMP_W'(1) > CMP_W'(MAX_DEGREE));
   assign v_top    = stack_ff[SP_W'(top_ff - TOP_W'(1))];
   assign slot     = self ? ca_ff + DW'(1) : cb_ff;

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      cur_in      = cur_ff;
      st_in       = st_ff;
      ca_in       = ca_ff;
      cb_in       = cb_ff;
      c_in        = c_ff;
      top_in      = top_ff;
      stack_in    = stack_ff;
      visited_in  = visited_ff;
      vcnt_in     = vcnt_ff;
      hold_v_in   = hold_v_ff;
      hold_idx_in = hold_idx_ff;
      hold_lab_in = hold_lab_ff;
      wen         = '0;
      lab_waddr   = '0;
      lab_wdata   = '0;
      lab_raddr   = '0;
      cnt_waddr   = '0;
      cnt_wdata   = '0;
      cnt_raddr   = '0;
      nbr_waddr   = '0;
      nbr_wdata   = '0;
      nbr_raddr   = '0;
      req_ch.ready = 1'b0;
      out_load    = 1'b0;
      out_st_in   = out_st_ff;
      out_idx_in  = out_idx_ff;
      out_lab_in  = out_lab_ff;
      out_vis_in  = out_vis_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               a_in     = req_ch.vertex_a;
               b_in     = req_ch.vertex_b;
               st_in    = ST_OK;
               state_in = S_ACK;
               case (req_ch.req_type)
                  REQ_CLEAR: begin
                     wen.clear  = 1'b1;
                     vcnt_in    = '0;
                     visited_in = '0;
                  end
                  REQ_VERTEX: begin
                     if (vcnt_ff >= VCW'(MAX_VERTICES)) begin
                        st_in = ST_TABLE;
                     end else begin
                        wen.lab_we = 1'b1;
                        lab_waddr  = VW'(vcnt_ff);
                        lab_wdata  = req_ch.label_in;
                        vcnt_in    = vcnt_ff + VCW'(1);
                     end
                  end
                  REQ_EDGE: begin
                     if (a_bad || b_bad) begin
                        st_in = ST_TABLE;
                     end else begin
                        cnt_raddr = VW'(req_ch.vertex_a);
                        state_in  = S_EA;
                     end
                  end
                  default: begin
                     visited_in = '0;
                     if (a_bad) begin
                        st_in = ST_TABLE;
                     end else begin
                        visited_in[VW'(req_ch.vertex_a)] = 1'b1;
                        stack_in[0] = req_ch.vertex_a;
                        top_in      = TOP_W'(1);
                        hold_v_in   = 1'b0;
                        cur_in      = req_ch.vertex_a;
                        lab_raddr   = VW'(req_ch.vertex_a);
                        state_in    = S_SLAB;
                     end
                  end
               endcase
            end
         end
         S_ACK: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_st_in   = st_ff;
               out_idx_in  = '0;
               out_lab_in  = '0;
               out_vis_in  = 1'b0;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EA: begin
            ca_in     = cnt_rdata;
            cnt_raddr = VW'(b_ff);
            state_in  = S_EB;
         end
         S_EB: begin
            cb_in = cnt_rdata;
            if (full) begin
               st_in    = ST_LIST;
               state_in = S_ACK;
            end else begin
               state_in = S_EC;
            end
         end
         S_EC: begin
            wen.nbr_we = 1'b1;
            nbr_waddr  = NAW'(VW'(a_ff)) * NAW'(MAX_DEGREE) + NAW'(ca_ff);
            nbr_wdata  = b_ff;
            wen.cnt_we = 1'b1;
            cnt_waddr  = VW'(a_ff);
            cnt_wdata  = ca_ff + DW'(1);
            state_in   = S_ED;
         end
         S_ED: begin
            wen.nbr_we = 1'b1;
            nbr_waddr  = NAW'(VW'(b_ff)) * NAW'(MAX_DEGREE) + NAW'(slot);
            nbr_wdata  = a_ff;
            wen.cnt_we = 1'b1;
            cnt_waddr  = VW'(b_ff);
            cnt_wdata  = slot + DW'(1);
            state_in   = S_ACK;
         end
         S_SLAB: begin
            lab_raddr = VW'(cur_ff);
            if (!hold_v_ff || out_free) begin
               if (hold_v_ff) begin
                  out_load    = 1'b1;
                  out_st_in   = ST_OK;
                  out_idx_in  = hold_idx_ff;
                  out_lab_in  = hold_lab_ff;
                  out_vis_in  = 1'b1;
                  out_last_in = 1'b0;
               end
               hold_v_in   = 1'b1;
               hold_idx_in = cur_ff;
               hold_lab_in = lab_rdata;
               state_in    = S_STOP;
            end
         end
         S_STOP: begin
            cur_in    = v_top;
            cnt_raddr = VW'(v_top);
            state_in  = S_SCNT;
         end
         S_SCNT: begin
            c_in     = cnt_rdata;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (c_ff == '0) begin
               top_in   = top_ff - TOP_W'(1);
               state_in = (top_ff == TOP_W'(1)) ? S_SFIN : S_STOP;
            end else begin
               c_in      = c_ff - DW'(1);
               nbr_raddr = NAW'(VW'(cur_ff)) * NAW'(MAX_DEGREE) + NAW'(c_ff - DW'(1));
               state_in  = S_SNB;
            end
         end
         S_SNB: begin
            if (!visited_ff[VW'(nbr_rdata)]) begin
               visited_in[VW'(nbr_rdata)] = 1'b1;
               stack_in[SP_W'(top_ff)]    = nbr_rdata;
               top_in    = top_ff + TOP_W'(1);
               cur_in    = nbr_rdata;
               lab_raddr = VW'(nbr_rdata);
               state_in  = S_SLAB;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SFIN: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_st_in   = ST_OK;
               out_idx_in  = hold_idx_ff;
               out_lab_in  = hold_lab_ff;
               out_vis_in  = 1'b1;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_v_ff   <= 1'b0;
         vcnt_ff    <= '0;
         visited_ff <= '0;
         top_ff     <= '0;
         hold_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_v_ff   <= out_v_in;
         vcnt_ff    <= vcnt_in;
         visited_ff <= visited_in;
         top_ff     <= top_in;
         hold_v_ff  <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      st_ff       <= st_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      c_ff        <= c_in;
      stack_ff    <= stack_in;
      hold_idx_ff <= hold_idx_in;
      hold_lab_ff <= hold_lab_in;
      out_st_ff   <= out_st_in;
      out_idx_ff  <= out_idx_in;
      out_lab_ff  <= out_lab_in;
      out_vis_ff  <= out_vis_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.status        = out_st_ff;
   assign rsp_ch.visited_index = out_idx_ff;
   assign rsp_ch.visited_label = out_lab_ff;
   assign rsp_ch.is_visit      = out_vis_ff;
   assign rsp_ch.last          = out_last_ff;

endmodule
`default_nettype wire

// ----- design/gde_checker.sv -----
`default_nettype none
module gde_checker
   import gde_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [ST_W-1:0]  status,
   input wire logic [IDX_W-1:0] visited_index,
   input wire logic [LAB_W-1:0] visited_label,
   input wire logic             is_visit,
   input wire logic             last
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
         $stable(visited_index) && $stable(visited_label) && $stable(is_visit) &&
         $stable(last))
      else $error("stalled result changed");

   a_ack_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_visit |-> last && visited_index == '0 && visited_label == '0)
      else $error("malformed acknowledgement");

   a_visit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_visit |-> status == ST_OK)
      else $error("visit with error status");

endmodule

bind graph_dfs_engine gde_checker u_gde_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .visited_index(rsp_ch.visited_index),
   .visited_label(rsp_ch.visited_label),
   .is_visit     (rsp_ch.is_visit),
   .last         (rsp_ch.last)
);
`default_nettype wire

// ----- bench/tb_graph_dfs_engine.sv -----
module tb_graph_dfs_engine;
   import gde_pkg::*;

   localparam int NV = 32;
   localparam int ND = 16;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic [IDX_W-1:0]        vidx;
      logic signed [LAB_W-1:0] vlab;
      logic                    is_visit;
      logic                    last;
   } visit_t;

   typedef struct {
      logic [REQ_W-1:0]        rt;
      logic [IDX_W-1:0]        a;
      logic [IDX_W-1:0]        b;
      logic signed [LAB_W-1:0] lab;
      bit                      has_exp;
      logic [ST_W-1:0]         exp_st;
   } stim_row_t;

   logic clock = 0;
   logic reset = 1;

   gde_req_if req_ch ();
   gde_rsp_if rsp_ch ();

   graph_dfs_engine dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic signed [LAB_W-1:0] g_labels [NV];
   int unsigned             g_vcount;
   logic [IDX_W-1:0]        g_nbrs [NV][ND];
   int unsigned             g_deg [NV];

   visit_t      result_fifo[$];
   int          err_count = 0;
   int          rsp_count = 0;
   int          visit_count = 0;
   int          send_idle_pct = 9;
   int          recv_idle_pct = 68;
   bit          recv_hold = 0;
   int          hold_cycles = 0;

   function automatic visit_t ack(logic [ST_W-1:0] st);
      visit_t r;
      r = '0;
      r.status = st;
      r.last = 1;
      return r;
   endfunction

   function automatic visit_t visit(int v);
      visit_t r;
      r = '0;
      r.status = ST_OK;
      r.vidx = v[IDX_W-1:0];
      r.vlab = g_labels[v];
      r.is_visit = 1;
      return r;
   endfunction

   task automatic graph_predict(stim_row_t s);
      int          stk[$];
      bit          seen [NV];
      int          v, w, c, a, b;
      bit          pushed;
      visit_t      vq[$];
      a = s.a;
      b = s.b;
      case (s.rt)
         REQ_CLEAR: begin
            foreach (g_labels[i]) begin
               g_labels[i] = 0;
               g_deg[i] = 0;
            end
            g_vcount = 0;
            result_fifo.push_back(ack(ST_OK));
         end
         REQ_VERTEX: begin
            if (g_vcount >= NV) result_fifo.push_back(ack(ST_TABLE));
            else begin
               g_labels[g_vcount] = s.lab;
               g_vcount++;
               result_fifo.push_back(ack(ST_OK));
            end
         end
         REQ_EDGE: begin
            if (a == b) begin
               if (g_deg[a] + 2 > ND) result_fifo.push_back(ack(ST_LIST));
               else begin
                  g_nbrs[a][g_deg[a]++] = a[IDX_W-1:0];
                  g_nbrs[a][g_deg[a]++] = a[IDX_W-1:0];
                  result_fifo.push_back(ack(ST_OK));
               end
            end else if (g_deg[a] + 1 > ND || g_deg[b] + 1 > ND) begin
               result_fifo.push_back(ack(ST_LIST));
            end else begin
               g_nbrs[a][g_deg[a]++] = b[IDX_W-1:0];
               g_nbrs[b][g_deg[b]++] = a[IDX_W-1:0];
               result_fifo.push_back(ack(ST_OK));
            end
         end
         default: begin
            foreach (seen[i]) seen[i] = 0;
            seen[a] = 1;
            vq.push_back(visit(a));
            stk.push_back(a);
            while (stk.size() > 0) begin
               v = stk[$];
               c = g_deg[v];
               pushed = 0;
               while (c > 0) begin
                  c--;
                  w = g_nbrs[v][c];
                  if (!seen[w]) begin
                     seen[w] = 1;
                     vq.push_back(visit(w));
                     stk.push_back(w);
                     pushed = 1;
                     break;
                  end
               end
               if (!pushed) void'(stk.pop_back());
            end
            vq[$].last = 1;
            foreach (vq[i]) result_fifo.push_back(vq[i]);
         end
      endcase
   endtask

   task automatic send_req(stim_row_t s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid    <= 1;
      req_ch.req_type <= s.rt;
      req_ch.vertex_a <= s.a;
      req_ch.vertex_b <= s.b;
      req_ch.label_in <= s.lab;
      do @(posedge clock); while (!req_ch.ready);
      graph_predict(s);
      if (s.has_exp && result_fifo[$].status !== s.exp_st) begin
         $display("%0t directed row: expected status %0d predicted %0d", $time,
                  s.exp_st, result_fifo[$].status);
         err_count++;
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 0;
      while (result_fifo.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic stim_row_t row(logic [REQ_W-1:0] rt, int a, int b, int lab,
                                     bit he = 0, logic [ST_W-1:0] es = ST_OK);
      stim_row_t s;
      s.rt = rt;
      s.a = a[IDX_W-1:0];
      s.b = b[IDX_W-1:0];
      s.lab = lab[LAB_W-1:0];
      s.has_exp = he;
      s.exp_st = es;
      return s;
   endfunction

   function automatic stim_row_t rand_row(int nv);
      int k;
      stim_row_t s;
      k = $urandom_range(99);
      s = row(REQ_EDGE, $urandom_range(nv - 1), $urandom_range(nv - 1), $urandom);
      if (k < 3) s.rt = REQ_CLEAR;
      else if (k < 25) s.rt = REQ_VERTEX;
      else if (k < 80) s.rt = REQ_EDGE;
      else s.rt = REQ_SEARCH;
      if ($urandom_range(9) == 0) begin
         s.a = IDX_W'($urandom);
         s.b = IDX_W'($urandom);
      end
      return s;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (recv_hold) begin
         rsp_ch.ready <= 0;
         if (hold_cycles > 0) hold_cycles--;
         else recv_hold <= 0;
      end else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      visit_t got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status   = rsp_ch.status;
         got.vidx     = rsp_ch.visited_index;
         got.vlab     = rsp_ch.visited_label;
         got.is_visit = rsp_ch.is_visit;
         got.last     = rsp_ch.last;
         rsp_count++;
         if (got.is_visit) visit_count++;
         if (result_fifo.size() == 0) begin
            $display("%0t unexpected result %p", $time, got);
            err_count++;
         end else begin
            want = result_fifo.pop_front();
            if (got !== want) begin
               $display("%0t mismatch: expected %p actual %p", $time, want, got);
               err_count++;
            end
         end
      end
   end

   initial begin
      #100000000;
      $display("tb_graph_dfs_engine failed");
      $finish;
   end

   initial begin
      stim_row_t dir[$];
      stim_row_t s;
      foreach (g_labels[i]) begin
         g_labels[i] = 0;
         g_deg[i] = 0;
      end
      g_vcount = 0;
      req_ch.valid = 0;
      req_ch.req_type = REQ_CLEAR;
      req_ch.vertex_a = 0;
      req_ch.vertex_b = 0;
      req_ch.label_in = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      dir.push_back(row(REQ_SEARCH, 0, 0, 0, 1, ST_OK));
      dir.push_back(row(REQ_VERTEX, 0, 0, 32767, 1, ST_OK));
      dir.push_back(row(REQ_VERTEX, 31, 31, -32768, 1, ST_OK));
      dir.push_back(row(REQ_VERTEX, 0, 0, -1, 1, ST_OK));
      dir.push_back(row(REQ_EDGE, 0, 1, 0, 1, ST_OK));
      dir.push_back(row(REQ_EDGE, 1, 2, 0, 1, ST_OK));
      dir.push_back(row(REQ_EDGE, 2, 2, 0, 1, ST_OK));
      dir.push_back(row(REQ_EDGE, 0, 31, 0, 1, ST_OK));
      dir.push_back(row(REQ_EDGE, 31, 0, 0, 1, ST_OK));
      dir.push_back(row(REQ_SEARCH, 0, 0, 0));
      dir.push_back(row(REQ_SEARCH, 31, 0, 0));
      dir.push_back(row(REQ_SEARCH, 17, 0, 0));
      dir.push_back(row(REQ_CLEAR, 0, 0, 0, 1, ST_OK));
      dir.push_back(row(REQ_SEARCH, 0, 0, 0));
      for (int i = 0; i < 8; i++) dir.push_back(row(REQ_EDGE, 5, 5, 0));
      dir.push_back(row(REQ_EDGE, 5, 5, 0, 1, ST_LIST));
      dir.push_back(row(REQ_EDGE, 5, 6, 0, 1, ST_LIST));
      dir.push_back(row(REQ_SEARCH, 5, 0, 0));
      foreach (dir[i]) send_req(dir[i]);
      drain_results();

      for (int i = 0; i < 33; i++) send_req(row(REQ_VERTEX, 0, 0, $urandom));
      drain_results();
      send_req(row(REQ_CLEAR, 0, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 68 : 0;
         recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 9 : 0;
         if (phase == 2) begin
            hold_cycles = 300;
            recv_hold = 1;
         end
         for (int i = 0; i < 12; i++) begin
            s = rand_row((phase == 1) ? 6 : NV);
            send_req(s);
            if (i == 6) drain_results();
         end
         for (int j = 0; j < 4; j++) send_req(row(REQ_SEARCH, $urandom_range(NV-1), 0, 0));
         drain_results();
         send_req(row(REQ_CLEAR, 0, 0, 0));
      end
      drain_results();
      repeat (50) @(negedge clock);

      $display("ran directed and random graph builds and searches: %0d results, %0d visits",
               rsp_count, visit_count);
      if (err_count == 0 && result_fifo.size() == 0) begin
         $display("tb_graph_dfs_engine passed");
      end else begin
         $display("tb_graph_dfs_engine failed");
      end
      $finish;
   end

endmodule
